### design/hsle_pkg.sv
package hsle_pkg;

   // Default store size and register reset value.
   localparam int STORE_BYTES_DEF = 256;
   localparam int IDLE_W = 14;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 14'd15000;

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int CODE_W = 10;
   localparam int CAUSE_W = 2;
   localparam int RSP_DATA_W = 16;

   // Status line prefix "HTTP/1.1 " and header terminator CR LF CR LF.
   localparam int PREFIX_LEN = 9;
   localparam int PREFIX_POS_W = 4;
   localparam logic [BYTE_W-1:0] PREFIX [PREFIX_LEN] = '{
      8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31, 8'h20
   };
   localparam int MARKER_LEN = 4;
   localparam int MARKER_POS_W = 2;
   localparam logic [BYTE_W-1:0] MARKER [MARKER_LEN] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

   localparam logic [BYTE_W-1:0] CHAR_H = 8'h48;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;

   // Input kinds.
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_IDLE = 1'b1;

   // End causes.
   localparam logic [CAUSE_W-1:0] CAUSE_TERM = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_FULL = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_IDLE = 2'd2;

   // One input word after unpacking.
   typedef struct packed {
      logic mode;
      logic [BYTE_W-1:0] rx_byte;
   } hsle_item_type;

   // One result word after unpacking.
   typedef struct packed {
      logic parse_ok;
      logic [CODE_W-1:0] status_code;
      logic [CAUSE_W-1:0] end_cause;
   } hsle_result_type;

   // Whitespace as skipped before the digits: space, TAB, LF, VT, FF, CR.
   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

endpackage

### design/hsle_parse.sv
module hsle_parse #(
   parameter int STORE_BYTES = hsle_pkg::STORE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic step_valid,
   input  hsle_pkg::hsle_item_type item,
   input  logic [hsle_pkg::IDLE_W-1:0] idle_limit,
   output logic done,
   output hsle_pkg::hsle_result_type result
);
   import hsle_pkg::*;

   localparam int CNT_W = $clog2(STORE_BYTES);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_BYTES - 1);

   // Digit parser phases.
   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_DIGIT = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   logic [PREFIX_POS_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic [MARKER_POS_W-1:0] term_pos_ff, term_pos_in;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [IDLE_W-1:0] idle_cnt_ff, idle_cnt_in;
   logic hdr_found_ff, hdr_found_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] dig_cnt_ff, dig_cnt_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic zero_seen_ff, zero_seen_in;

   logic [BYTE_W-1:0] b;
   logic [PREFIX_POS_W:0] hdr_next;
   logic [MARKER_POS_W:0] term_next;
   logic term_hit;
   logic [CODE_W-1:0] digit_val;

   assign b = item.rx_byte;
   assign digit_val = CODE_W'(b - CHAR_ZERO);

   // Step the matchers, the digit parser and the counters for one word.
   always_comb begin
      hdr_pos_in = hdr_pos_ff;
      term_pos_in = term_pos_ff;
      byte_cnt_in = byte_cnt_ff;
      idle_cnt_in = idle_cnt_ff;
      hdr_found_in = hdr_found_ff;
      phase_in = phase_ff;
      dig_cnt_in = dig_cnt_ff;
      code_in = code_ff;
      zero_seen_in = zero_seen_ff;
      hdr_next = '0;
      term_next = '0;
      term_hit = 1'b0;
      done = 1'b0;
      result = '0;

      if (step_valid) begin
         if (item.mode == MODE_IDLE) begin
            idle_cnt_in = idle_cnt_ff + 1'b1;
            if (idle_cnt_in >= idle_limit) begin
               done = 1'b1;
               result.end_cause = CAUSE_IDLE;
            end
         end else begin
            idle_cnt_in = '0;
            if (!zero_seen_ff) begin
               if (b == CHAR_NUL) begin
                  // A NUL ends the string; a pending digit phase closes.
                  zero_seen_in = 1'b1;
                  if (hdr_found_ff && phase_ff != PH_DONE) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  if (hdr_found_ff) begin
                     // Digit parser: skip leading whitespace, take up to three digits.
                     if (phase_ff != PH_DONE && !(phase_ff == PH_SKIP && is_space(b))) begin
                        if (is_digit(b)) begin
                           code_in = CODE_W'((code_ff << 3) + (code_ff << 1) + digit_val);
                           dig_cnt_in = dig_cnt_ff + 1'b1;
                           phase_in = (dig_cnt_in == 2'd3) ? PH_DONE : PH_DIGIT;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                  end else begin
                     // Status line prefix search.
                     if (hdr_pos_ff < PREFIX_POS_W'(PREFIX_LEN) && b == PREFIX[hdr_pos_ff]) begin
                        hdr_next = {1'b0, hdr_pos_ff} + 1'b1;
                     end else begin
                        hdr_next = (b == CHAR_H) ? (PREFIX_POS_W+1)'(1) : '0;
                     end
                     if (hdr_next >= (PREFIX_POS_W+1)'(PREFIX_LEN)) begin
                        hdr_found_in = 1'b1;
                        hdr_pos_in = '0;
                     end else begin
                        hdr_pos_in = hdr_next[PREFIX_POS_W-1:0];
                     end
                  end
                  // Header terminator search.
                  if (b == MARKER[term_pos_ff]) begin
                     term_next = {1'b0, term_pos_ff} + 1'b1;
                  end else begin
                     term_next = (b == CHAR_CR) ? (MARKER_POS_W+1)'(1) : '0;
                  end
                  term_hit = term_next[MARKER_POS_W];
                  term_pos_in = term_next[MARKER_POS_W-1:0];
               end
            end
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (byte_cnt_in >= FULL_COUNT) begin
               done = 1'b1;
               result.end_cause = CAUSE_FULL;
            end else if (term_hit) begin
               done = 1'b1;
               result.end_cause = CAUSE_TERM;
            end
         end

         // Report from the updated state, then clear for the next response.
         if (done) begin
            result.parse_ok = hdr_found_in && (dig_cnt_in != 2'd0);
            result.status_code = result.parse_ok ? code_in : '0;
            hdr_pos_in = '0;
            term_pos_in = '0;
            byte_cnt_in = '0;
            idle_cnt_in = '0;
            hdr_found_in = 1'b0;
            phase_in = PH_SKIP;
            dig_cnt_in = '0;
            code_in = '0;
            zero_seen_in = 1'b0;
         end
      end
   end

   // Response state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff <= '0;
         term_pos_ff <= '0;
         byte_cnt_ff <= '0;
         idle_cnt_ff <= '0;
         hdr_found_ff <= 1'b0;
         phase_ff <= PH_SKIP;
         dig_cnt_ff <= '0;
         code_ff <= '0;
         zero_seen_ff <= 1'b0;
      end else begin
         hdr_pos_ff <= hdr_pos_in;
         term_pos_ff <= term_pos_in;
         byte_cnt_ff <= byte_cnt_in;
         idle_cnt_ff <= idle_cnt_in;
         hdr_found_ff <= hdr_found_in;
         phase_ff <= phase_in;
         dig_cnt_ff <= dig_cnt_in;
         code_ff <= code_in;
         zero_seen_ff <= zero_seen_in;
      end
   end

endmodule

### design/http_status_line_extractor_core.sv
// Channel | Direction | Contents
// req     | in        | tdata[7:0] = rx_byte; tuser = mode (0 byte, 1 idle tick)
// rsp     | out       | tdata[0] = parse_ok, [10:1] = status_code, [12:11] = end_cause
// csr     | in        | csr_wr_data = idle_limit, written when csr_wr_en is high
//
// One word is taken per cycle while the result register is free. A word is held in the input
// register, then the parser updates its matchers and counters and, when a response ends, loads
// the result register.
// Synchronous reset clears all response state and sets idle_limit to 15000.
// A result held back by rsp_tready stalls the input register, and req_tready drops.
module http_status_line_extractor_core #(
   parameter int STORE_BYTES = hsle_pkg::STORE_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   input  logic req_tuser,         // mode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [hsle_pkg::RSP_DATA_W-1:0] rsp_tdata, // parse_ok, status_code, end_cause, zeros
   input  logic csr_wr_en,
   input  logic [hsle_pkg::IDLE_W-1:0] csr_wr_data
);
   import hsle_pkg::*;

   logic in_valid_ff;
   hsle_item_type in_item_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [IDLE_W-1:0] idle_limit_ff;

   logic out_free;
   logic process;
   logic done;
   hsle_result_type result;

   // The held word is processed whenever the result register can take a result.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign process = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || process;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // Idle limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         idle_limit_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.mode <= req_tuser;
         in_item_ff.rx_byte <= req_tdata;
      end
   end

   hsle_parse #(
      .STORE_BYTES(STORE_BYTES)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .step_valid(process),
      .item(in_item_ff),
      .idle_limit(idle_limit_ff),
      .done(done),
      .result(result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && done) begin
         rsp_data_ff <= RSP_DATA_W'({result.end_cause, result.status_code, result.parse_ok});
      end
   end

endmodule

### tb/sv/http_status_line_extractor_core_tb.sv
module http_status_line_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsle_pkg::*;

   localparam int RANDOM_WORDS = 600;
   localparam int PHASE_WORDS = 150;
   localparam int MAX_GAP = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 10;

   // Progress of the digit parser after the status line prefix.
   typedef enum logic [1:0] {
      SKIP_BLANKS,
      TAKE_DIGITS,
      DIGITS_DONE
   } digit_phase_type;

   // Tracks one response at a time and keeps the status results still owed by the block.
   class status_code_scoreboard_type;
      logic [IDLE_W-1:0] idle_limit;
      logic [IDLE_W-1:0] idle_count;
      int unsigned prefix_pos;
      int unsigned marker_pos;
      int unsigned byte_count;
      bit header_found;
      bit nul_seen;
      digit_phase_type phase;
      int unsigned digit_count;
      int unsigned code_value;
      hsle_result_type expected_q[$];
      int unsigned errors;

      function new();
         idle_limit = IDLE_LIMIT_RESET;
         errors = 0;
         clear_response();
      endfunction

      function void clear_response();
         idle_count = '0;
         prefix_pos = 0;
         marker_pos = 0;
         byte_count = 0;
         header_found = 1'b0;
         nul_seen = 1'b0;
         phase = SKIP_BLANKS;
         digit_count = 0;
         code_value = 0;
      endfunction

      function bit is_blank(logic [BYTE_W-1:0] b);
         return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
      endfunction

      function void close_response(logic [CAUSE_W-1:0] cause);
         hsle_result_type res;
         bit ok;
         ok = header_found && (digit_count > 0);
         res.parse_ok = ok;
         res.status_code = ok ? code_value[CODE_W-1:0] : '0;
         res.end_cause = cause;
         expected_q.push_back(res);
         clear_response();
      endfunction

      function void take_digit(logic [BYTE_W-1:0] b);
         if (phase == DIGITS_DONE) return;
         if (phase == SKIP_BLANKS && is_blank(b)) return;
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            code_value = code_value * 10 + (b - CHAR_ZERO);
            digit_count++;
            phase = (digit_count >= 3) ? DIGITS_DONE : TAKE_DIGITS;
         end else begin
            // A sign or any other character ends the number.
            phase = DIGITS_DONE;
         end
      endfunction

      function void match_prefix(logic [BYTE_W-1:0] b);
         int unsigned p;
         p = prefix_pos;
         if (p < PREFIX_LEN && b == PREFIX[p])
            p++;
         else
            p = (b == CHAR_H) ? 1 : 0;
         if (p >= PREFIX_LEN) begin
            header_found = 1'b1;
            p = 0;
         end
         prefix_pos = p;
      endfunction

      function bit match_marker(logic [BYTE_W-1:0] b);
         int unsigned p;
         p = marker_pos;
         if (p < MARKER_LEN && b == MARKER[p])
            p++;
         else
            p = (b == CHAR_CR) ? 1 : 0;
         marker_pos = (p >= MARKER_LEN) ? 0 : p;
         return p >= MARKER_LEN;
      endfunction

      // Called for every word the block accepts.
      function void note_word(logic mode, logic [BYTE_W-1:0] b);
         bit term;
         term = 1'b0;
         if (mode == MODE_IDLE) begin
            idle_count = idle_count + 1'b1;
            if (idle_count >= idle_limit) close_response(CAUSE_IDLE);
            return;
         end
         idle_count = '0;
         // Past a NUL the string has ended: only the byte count moves on.
         if (!nul_seen) begin
            if (b == CHAR_NUL) begin
               nul_seen = 1'b1;
               if (header_found) take_digit(b);
            end else begin
               if (header_found)
                  take_digit(b);
               else
                  match_prefix(b);
               term = match_marker(b);
            end
         end
         byte_count++;
         // A full store takes precedence over a terminator on the same byte.
         if (byte_count >= STORE_BYTES_DEF - 1)
            close_response(CAUSE_FULL);
         else if (term)
            close_response(CAUSE_TERM);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         hsle_result_type want;
         logic got_ok;
         logic [CODE_W-1:0] got_code;
         logic [CAUSE_W-1:0] got_cause;
         got_ok = d[0];
         got_code = d[CODE_W:1];
         got_cause = d[CODE_W+CAUSE_W:CODE_W+1];
         if (expected_q.size() == 0) begin
            $error("unexpected result word, tdata %h", d);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got_ok !== want.parse_ok) begin
            $error("parse_ok: expected %0d, actual %0d", want.parse_ok, got_ok);
            errors++;
         end
         if (got_code !== want.status_code) begin
            $error("status_code: expected %0d, actual %0d", want.status_code, got_code);
            errors++;
         end
         if (got_cause !== want.end_cause) begin
            $error("end_cause: expected %0d, actual %0d", want.end_cause, got_cause);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;   // rx_byte
   logic req_tuser;         // mode
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata; // parse_ok, status_code, end_cause, zeros
   logic csr_wr_en;
   logic [IDLE_W-1:0] csr_wr_data;

   status_code_scoreboard_type sb = new();

   int req_gap_max = MAX_GAP;
   int rsp_gap_max = MAX_GAP;
   bit long_hold_req = 1'b0;
   int unsigned words_sent = 0;
   logic [IDLE_W-1:0] cur_limit = IDLE_LIMIT_RESET;

   http_status_line_extractor_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both channels are observed on the rising edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Result side: a random stall before each word, with one long hold on request.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = long_hold_req ? LONG_HOLD_CYCLES : $urandom_range(0, rsp_gap_max);
         long_hold_req = 1'b0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // Offers one word after a random gap and returns at the falling edge after acceptance.
   task automatic send_word(input logic mode, input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(MODE_BYTE, s[i]);
   endtask

   task automatic send_idle_ticks(input int n);
      for (int i = 0; i < n; i++) send_word(MODE_IDLE, 8'($urandom_range(0, 255)));
   endtask

   // Holds off the sender until the block has delivered everything it owes.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_idle_limit(input logic [IDLE_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.idle_limit = v;
      cur_limit = v;
   endtask

   function automatic logic [7:0] pick_blank();
      logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      return blanks[$urandom_range(0, 5)];
   endfunction

   // Mostly well-formed responses with random content, plus noise and oversized bodies.
   task automatic send_random_response();
      int kind;
      int n;
      logic [7:0] sign;
      kind = $urandom_range(0, 39);
      if (kind < 28) begin
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) send_word(MODE_BYTE, 8'($urandom_range(1, 255)));
         if (kind == 27)
            send_text("HTTP/1.");
         else
            send_text("HTTP/1.1 ");
         n = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) send_word(MODE_BYTE, pick_blank());
         if ($urandom_range(0, 9) == 0) begin
            sign = $urandom_range(0, 1) ? "+" : "-";
            send_word(MODE_BYTE, sign);
         end
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            send_word(MODE_BYTE, CHAR_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 7) == 0) send_word(MODE_BYTE, CHAR_NUL);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_idle_ticks($urandom_range(0, cur_limit - 1));
            send_word(MODE_BYTE, 8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 4) != 0)
            send_text("\r\n\r\n");
         else
            send_idle_ticks(int'(cur_limit));
      end else if (kind < 39) begin
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++)
            send_word($urandom_range(0, 3) == 0 ? MODE_IDLE : MODE_BYTE,
                      8'($urandom_range(0, 255)));
         send_idle_ticks(int'(cur_limit));
      end else begin
         send_text("HTTP/1.1 503 ");
         for (int i = 0; i < STORE_BYTES_DEF; i++)
            send_word(MODE_BYTE, 8'($urandom_range(1, 255)));
      end
   endtask

   initial begin
      int unsigned rand_start;
      int unsigned phase_end;
      logic [IDLE_W-1:0] lim;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_BYTE;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default idle limit: status line variants ended by the header terminator.
      send_text("HTTP/1.1 200 OK\r\n\r\n");
      send_text("HHTTP/1.1 ");
      send_word(MODE_BYTE, CHAR_TAB);
      send_word(MODE_BYTE, 8'h0B);
      send_word(MODE_BYTE, 8'h0C);
      send_text("\r\n 404\r\n\r\n");
      send_text("HTTP/1.1 -7\r\n\r\n");
      send_text("HTTP/1.1 0001\r\n\r\n");
      send_word(MODE_BYTE, 8'hFF);
      send_text("HTTP/1.1 999 x\r\n\r\n");
      // The terminator lands on the byte that fills the store.
      for (int i = 0; i < STORE_BYTES_DEF - 5; i++) send_word(MODE_BYTE, "a");
      send_text("\r\n\r\n");
      // Idle ticks well below the reset idle limit leave the response open.
      send_idle_ticks(40);
      send_text("HTTP/1.1 204\r\n\r\n");
      wait_drained();

      // Largest idle limit.
      write_idle_limit('1);
      send_text("HTTP/1.1 301");
      send_idle_ticks(60);
      send_text("\r\n\r\n");
      wait_drained();

      // Zero idle limit: every idle tick closes a response; NUL stops the parser.
      write_idle_limit('0);
      send_text("HTTP/1.1 2");
      send_word(MODE_BYTE, CHAR_NUL);
      send_text(" 00\r\n\r\n");
      send_idle_ticks(2);
      send_word(MODE_BYTE, CHAR_NUL);
      send_text("HTTP/1.1 500");
      send_idle_ticks(1);
      wait_drained();

      // Idle limit of one.
      write_idle_limit(IDLE_W'(1));
      send_text("HTTP/1.1 42");
      send_idle_ticks(1);
      wait_drained();

      // Random phases, each with its own idle limit and idling pattern.
      rand_start = words_sent;
      for (int ph = 0; words_sent - rand_start < RANDOM_WORDS; ph++) begin
         wait_drained();
         case (ph % 4)
            0: lim = IDLE_W'(1);
            1: lim = IDLE_W'(2);
            default: lim = IDLE_W'($urandom_range(3, 40));
         endcase
         write_idle_limit(lim);
         req_gap_max = (ph % 5 == 2 || ph % 5 == 3) ? 0 : MAX_GAP;
         rsp_gap_max = (ph % 5 == 2 || ph % 5 == 4) ? 0 : MAX_GAP;
         if (ph == 1) long_hold_req = 1'b1;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_random_response();
      end

      wait_drained();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
